### rtl/gpo_pkg.sv
// shared constants and coefficient tables for the precession/obliquity unit
package gpo_pkg;

    localparam int TERM_SLOTS   = 10;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int PHASE_W      = 32;
    localparam int TIME_W       = 32;
    localparam int OUT_W        = 48;
    localparam int RECIP_W      = 37;
    localparam int RECIP_LO_W   = 16;
    localparam int COEF_W       = 30;
    localparam int CXY_W        = 34;
    localparam int CZ_W         = 33;
    localparam int FRONT_STAGES = 5;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // polynomial coefficients, rounded to nearest
    localparam logic signed [OUT_W-1:0] P0_Q16 =
        48'((64'sd7907295950 * 64'sd65536 + 64'sd500000) / 64'sd1000000);
    localparam logic signed [32:0] P1_Q19 =
        33'((64'sd5044374034 * 64'sd524288 + 64'sd500000) / 64'sd1000000);
    localparam logic signed [21:0] P2_Q28 =
        22'((64'sd713473 * (64'sd1 <<< 28) + 64'sd50000000) / 64'sd100000000);
    localparam logic signed [22:0] P3_Q49 =
        23'((64'sd6 * (64'sd1 <<< 49) + 64'sd500000000) / 64'sd1000000000);
    localparam logic signed [OUT_W-1:0] E0_Q16 =
        48'((64'sd83973876448 * 64'sd65536 + 64'sd500000) / 64'sd1000000);
    localparam logic signed [32:0] E1_Q36 =
        33'((64'sd425899 * (64'sd1 <<< 36) + 64'sd5000000) / 64'sd10000000);
    localparam logic signed [21:0] E2_Q40 =
        22'((64'sd113 * (64'sd1 <<< 40) + 64'sd50000000) / 64'sd100000000);

    // millionths of an arcsecond to q16, ties away from zero
    function automatic logic signed [COEF_W-1:0] q16s(input longint m);
        longint r;
        r = (m >= 0) ? (m * 65536 + 500000) / 1000000 : (m * 65536 - 500000) / 1000000;
        return COEF_W'(r);
    endfunction

    localparam logic signed [COEF_W-1:0] TERM_PC [TERM_SLOTS] = '{
        q16s(-64'sd6180062400), q16s(-64'sd2721869299), q16s(64'sd1460746498),
        q16s(-64'sd1838488899), q16s(64'sd949518077),   q16s(64'sd32701460),
        q16s(64'sd598054819),   q16s(-64'sd293145284),  q16s(64'sd66354942),
        q16s(64'sd18894136)
    };
    localparam logic signed [COEF_W-1:0] TERM_EC [TERM_SLOTS] = '{
        q16s(64'sd807904635),   q16s(-64'sd177959383),  q16s(64'sd371942696),
        q16s(-64'sd176029134),  q16s(-64'sd89154030),   q16s(-64'sd336048179),
        q16s(-64'sd17415730),   q16s(-64'sd28084479),   q16s(64'sd21456146),
        q16s(64'sd30917011)
    };
    localparam logic signed [COEF_W-1:0] TERM_PS [TERM_SLOTS] = '{
        q16s(-64'sd2434845716), q16s(64'sd538034071),   q16s(-64'sd1245689351),
        q16s(64'sd529220775),   q16s(64'sd277195375),   q16s(64'sd945979710),
        q16s(-64'sd955163661),  q16s(64'sd93894079),    q16s(64'sd671968),
        q16s(-64'sd184663935)
    };
    localparam logic signed [COEF_W-1:0] TERM_ES [TERM_SLOTS] = '{
        q16s(-64'sd2056455197), q16s(-64'sd912727303),  q16s(64'sd447710000),
        q16s(-64'sd611297411),  q16s(64'sd315900626),   q16s(64'sd12390157),
        q16s(-64'sd15922155),   q16s(-64'sd102870153),  q16s(64'sd24123484),
        q16s(64'sd2512708)
    };

    // reciprocal periods, turns per century in q44
    localparam logic [RECIP_W-1:0] TERM_RECIP [TERM_SLOTS] = '{
        RECIP_W'(((64'd100 << 44) + 64'd20495) / 64'd40990),
        RECIP_W'(((64'd100 << 44) + 64'd19807) / 64'd39615),
        RECIP_W'(((64'd100 << 44) + 64'd26845) / 64'd53691),
        RECIP_W'(((64'd100 << 44) + 64'd20145) / 64'd40290),
        RECIP_W'(((64'd100 << 44) + 64'd20857) / 64'd41715),
        RECIP_W'(((64'd100 << 44) + 64'd14446) / 64'd28892),
        RECIP_W'(((64'd100 << 44) + 64'd202148) / 64'd404297),
        RECIP_W'(((64'd100 << 44) + 64'd15245) / 64'd30490),
        RECIP_W'(((64'd100 << 44) + 64'd14073) / 64'd28146),
        RECIP_W'(((64'd100 << 44) + 64'd10219) / 64'd20438)
    };

    // arctangent of 2^-i in q0.32 turns
    localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5
    };

endpackage

### rtl/gpo_front.sv
// front end: takes time values, forms term phases and the polynomial parts
module gpo_front #(
    parameter int NUM_TERMS = 10
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic signed [gpo_pkg::TIME_W-1:0]              in_time,
    output logic                                           out_valid,
    input  logic                                           out_full,
    output logic [NUM_TERMS-1:0][gpo_pkg::PHASE_W-1:0]     out_phase,
    output logic [gpo_pkg::OUT_W-1:0]                      out_pa,
    output logic [gpo_pkg::OUT_W-1:0]                      out_ea
);

    localparam int PW = gpo_pkg::PHASE_W;
    localparam int OW = gpo_pkg::OUT_W;
    localparam int LW = gpo_pkg::RECIP_LO_W;

    logic                          fe;
    logic [gpo_pkg::FRONT_STAGES-1:0] v_reg;

    logic signed [31:0]  t1_reg, t2_reg;
    logic signed [48:0]  pl2_reg [NUM_TERMS];
    logic signed [48:0]  pl2_next [NUM_TERMS];
    logic signed [53:0]  ph2_reg [NUM_TERMS];
    logic signed [53:0]  ph2_next [NUM_TERMS];
    logic signed [63:0]  tt2_reg, tt2_next;
    logic signed [64:0]  m1p2_reg, m1p2_next, m1e2_reg, m1e2_next;

    logic [NUM_TERMS-1:0][PW-1:0] ph3_reg, ph3_next, ph4_reg, ph5_reg;
    logic signed [43:0]  t2q20_3_reg, t2q20_3_next;
    logic signed [63:0]  t3_3_reg, t3_3_next;
    logic [OW-1:0]       r1p3_reg, r1p3_next, r1e3_reg, r1e3_next;
    logic [OW-1:0]       r1p4_reg, r1e4_reg;

    logic signed [65:0]  m2p4_reg, m2p4_next, m2e4_reg, m2e4_next;
    logic signed [66:0]  m3_4_reg, m3_4_next;

    logic [OW-1:0]       pa5_reg, pa5_next, ea5_reg, ea5_next;

    assign fe        = !(v_reg[gpo_pkg::FRONT_STAGES-1] && out_full);
    assign in_ready  = fe;
    assign out_valid = v_reg[gpo_pkg::FRONT_STAGES-1];
    assign out_phase = ph5_reg;
    assign out_pa    = pa5_reg;
    assign out_ea    = ea5_reg;

    // products of time with itself, coefficients and split reciprocals
    always_comb begin
        for (int k = 0; k < NUM_TERMS; k++) begin
            pl2_next[k] = t1_reg * $signed({1'b0, gpo_pkg::TERM_RECIP[k][LW-1:0]});
            ph2_next[k] = t1_reg *
                $signed({1'b0, gpo_pkg::TERM_RECIP[k][gpo_pkg::RECIP_W-1:LW]});
        end
        tt2_next  = t1_reg * t1_reg;
        m1p2_next = t1_reg * gpo_pkg::P1_Q19;
        m1e2_next = t1_reg * gpo_pkg::E1_Q36;
    end

    // phase recombination, square shifts, linear rounding
    always_comb begin
        logic [63:0]        s;
        logic signed [31:0] t2q8;
        logic signed [64:0] r1p_full, r1e_full;
        for (int k = 0; k < NUM_TERMS; k++) begin
            s = {ph2_reg[k][63-LW:0], {LW{1'b0}}} + {{(64-49){pl2_reg[k][48]}}, pl2_reg[k]};
            ph3_next[k] = s[63:32];
        end
        t2q20_3_next = tt2_reg[63:20];
        t2q8         = tt2_reg[63:32];
        t3_3_next    = t2q8 * t2_reg;
        r1p_full     = (m1p2_reg + (65'sd1 <<< 22)) >>> 23;
        r1e_full     = (m1e2_reg + (65'sd1 <<< 39)) >>> 40;
        r1p3_next    = r1p_full[OW-1:0];
        r1e3_next    = r1e_full[OW-1:0];
    end

    // quadratic and cubic products
    always_comb begin
        logic signed [43:0] t3q8;
        t3q8      = 44'(t3_3_reg >>> 20);
        m2p4_next = gpo_pkg::P2_Q28 * t2q20_3_reg;
        m2e4_next = gpo_pkg::E2_Q40 * t2q20_3_reg;
        m3_4_next = gpo_pkg::P3_Q49 * t3q8;
    end

    // polynomial sums, modulo the output width
    always_comb begin
        logic signed [65:0] r2p, r2e;
        logic signed [66:0] r3;
        r2p      = (m2p4_reg + (66'sd1 <<< 31)) >>> 32;
        r2e      = (m2e4_reg + (66'sd1 <<< 43)) >>> 44;
        r3       = (m3_4_reg + (67'sd1 <<< 40)) >>> 41;
        pa5_next = gpo_pkg::P0_Q16 + r1p4_reg - r2p[OW-1:0] + r3[OW-1:0];
        ea5_next = gpo_pkg::E0_Q16 - r1e4_reg - r2e[OW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (fe) begin
            v_reg <= {v_reg[gpo_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (fe) begin
            t1_reg      <= in_time;
            t2_reg      <= t1_reg;
            pl2_reg     <= pl2_next;
            ph2_reg     <= ph2_next;
            tt2_reg     <= tt2_next;
            m1p2_reg    <= m1p2_next;
            m1e2_reg    <= m1e2_next;
            ph3_reg     <= ph3_next;
            t2q20_3_reg <= t2q20_3_next;
            t3_3_reg    <= t3_3_next;
            r1p3_reg    <= r1p3_next;
            r1e3_reg    <= r1e3_next;
            ph4_reg     <= ph3_reg;
            r1p4_reg    <= r1p3_reg;
            r1e4_reg    <= r1e3_reg;
            m2p4_reg    <= m2p4_next;
            m2e4_reg    <= m2e4_next;
            m3_4_reg    <= m3_4_next;
            ph5_reg     <= ph4_reg;
            pa5_reg     <= pa5_next;
            ea5_reg     <= ea5_next;
        end
    end

endmodule

### rtl/gpo_queue.sv
// small register queue between front and back ends
module gpo_queue #(
    parameter int WIDTH = 416,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/gpo_cordic.sv
// pipelined rotation cordic, phase in turns to sine and cosine
module gpo_cordic #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [gpo_pkg::PHASE_W-1:0]       phase,
    output logic signed [ANGLE_FRAC_BITS+2:0] sin_o,
    output logic signed [ANGLE_FRAC_BITS+2:0] cos_o
);

    localparam int N  = gpo_pkg::CORDIC_STEPS;
    localparam int XW = gpo_pkg::CXY_W;
    localparam int ZW = gpo_pkg::CZ_W;
    localparam int SW = ANGLE_FRAC_BITS + 3;
    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [XW-1:0] HALF = XW'(64'sd1 <<< (SH - 1));

    logic signed [XW-1:0] x_reg [N+1];
    logic signed [XW-1:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    logic [1:0]           q_reg [N+1];
    logic signed [XW-1:0] x_next [N];
    logic signed [XW-1:0] y_next [N];
    logic signed [ZW-1:0] z_next [N];

    logic [31:0]          a;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] rs_full, rc_full;
    logic signed [SW-1:0] rs, rc;
    logic signed [SW-1:0] sin_reg, sin_next, cos_reg, cos_next;

    // fold to the nearest quarter turn
    assign a  = phase + 32'h2000_0000;
    assign z0 = $signed({{(ZW-30){1'b0}}, a[29:0]}) - ZW'(64'sd536870912);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (z_reg[i] >= 0) begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - ZW'(gpo_pkg::ATAN_TURNS[i]);
            end else begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + ZW'(gpo_pkg::ATAN_TURNS[i]);
            end
        end
    end

    always_comb begin
        rs_full = (y_reg[N] + HALF) >>> SH;
        rc_full = (x_reg[N] + HALF) >>> SH;
        rs      = rs_full[SW-1:0];
        rc      = rc_full[SW-1:0];
        unique case (q_reg[N])
            2'd0: begin sin_next = rs;  cos_next = rc;  end
            2'd1: begin sin_next = rc;  cos_next = -rs; end
            2'd2: begin sin_next = -rs; cos_next = -rc; end
            default: begin sin_next = -rc; cos_next = rs; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= gpo_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
            q_reg[0] <= a[31:30];
            for (int i = 0; i < N; i++) begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
                q_reg[i+1] <= q_reg[i];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

### rtl/gpo_back.sv
// back end: cordic lanes, periodic terms, final sums and output register
module gpo_back #(
    parameter int NUM_TERMS       = 10,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_avail,
    output logic                                       in_pop,
    input  logic [NUM_TERMS-1:0][gpo_pkg::PHASE_W-1:0] in_phase,
    input  logic [gpo_pkg::OUT_W-1:0]                  in_pa,
    input  logic [gpo_pkg::OUT_W-1:0]                  in_ea,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [gpo_pkg::OUT_W-1:0]                  out_pa,
    output logic [gpo_pkg::OUT_W-1:0]                  out_ea
);

    localparam int CL  = gpo_pkg::CORDIC_LAT;
    localparam int LAT = CL + 4;
    localparam int OW  = gpo_pkg::OUT_W;
    localparam int SW  = ANGLE_FRAC_BITS + 3;
    localparam int MW  = gpo_pkg::COEF_W + SW;
    localparam int NP  = (NUM_TERMS + 1) / 2;
    localparam logic signed [MW:0] HALF = (MW+1)'(64'sd1 <<< (ANGLE_FRAC_BITS - 1));

    logic           be;
    logic [LAT-1:0] vld_reg;

    logic signed [SW-1:0] sn [NUM_TERMS];
    logic signed [SW-1:0] cs [NUM_TERMS];

    logic signed [MW-1:0] pcc_reg [NUM_TERMS];
    logic signed [MW-1:0] pss_reg [NUM_TERMS];
    logic signed [MW-1:0] ecc_reg [NUM_TERMS];
    logic signed [MW-1:0] ess_reg [NUM_TERMS];
    logic [OW-1:0]        tp_reg [NUM_TERMS];
    logic [OW-1:0]        tp_next [NUM_TERMS];
    logic [OW-1:0]        te_reg [NUM_TERMS];
    logic [OW-1:0]        te_next [NUM_TERMS];
    logic [OW-1:0]        sp_reg [NP];
    logic [OW-1:0]        sp_next [NP];
    logic [OW-1:0]        se_reg [NP];
    logic [OW-1:0]        se_next [NP];
    logic [OW-1:0]        pa_dly_reg [CL+3];
    logic [OW-1:0]        ea_dly_reg [CL+3];
    logic [OW-1:0]        opa_reg, opa_next, oea_reg, oea_next;

    assign be        = !vld_reg[LAT-1] || out_ready;
    assign in_pop    = be && in_avail;
    assign out_valid = vld_reg[LAT-1];
    assign out_pa    = opa_reg;
    assign out_ea    = oea_reg;

    for (genvar k = 0; k < NUM_TERMS; k++) begin : g_lane
        gpo_cordic #(
            .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
        ) u_cordic (
            .aclk  (aclk),
            .en    (be),
            .phase (in_phase[k]),
            .sin_o (sn[k]),
            .cos_o (cs[k])
        );
    end

    // each term pair rounded once, then folded in pairs
    always_comb begin
        logic signed [MW:0] sp_full, se_full;
        for (int k = 0; k < NUM_TERMS; k++) begin
            sp_full    = ((MW+1)'(pcc_reg[k]) + (MW+1)'(pss_reg[k]) + HALF) >>> ANGLE_FRAC_BITS;
            se_full    = ((MW+1)'(ecc_reg[k]) + (MW+1)'(ess_reg[k]) + HALF) >>> ANGLE_FRAC_BITS;
            tp_next[k] = OW'(sp_full);
            te_next[k] = OW'(se_full);
        end
        for (int j = 0; j < NP; j++) begin
            sp_next[j] = tp_reg[2*j];
            se_next[j] = te_reg[2*j];
            if (2*j + 1 < NUM_TERMS) begin
                sp_next[j] = tp_reg[2*j] + tp_reg[2*j+1];
                se_next[j] = te_reg[2*j] + te_reg[2*j+1];
            end
        end
        opa_next = pa_dly_reg[CL+2];
        oea_next = ea_dly_reg[CL+2];
        for (int j = 0; j < NP; j++) begin
            opa_next = opa_next + sp_reg[j];
            oea_next = oea_next + se_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (be) begin
            vld_reg <= {vld_reg[LAT-2:0], in_avail};
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            pa_dly_reg[0] <= in_pa;
            ea_dly_reg[0] <= in_ea;
            for (int i = 1; i < CL + 3; i++) begin
                pa_dly_reg[i] <= pa_dly_reg[i-1];
                ea_dly_reg[i] <= ea_dly_reg[i-1];
            end
            for (int k = 0; k < NUM_TERMS; k++) begin
                pcc_reg[k] <= gpo_pkg::TERM_PC[k] * cs[k];
                pss_reg[k] <= gpo_pkg::TERM_PS[k] * sn[k];
                ecc_reg[k] <= gpo_pkg::TERM_EC[k] * cs[k];
                ess_reg[k] <= gpo_pkg::TERM_ES[k] * sn[k];
            end
            tp_reg  <= tp_next;
            te_reg  <= te_next;
            sp_reg  <= sp_next;
            se_reg  <= se_next;
            opa_reg <= opa_next;
            oea_reg <= oea_next;
        end
    end

endmodule

### rtl/general_precession_obliquity_unit.sv
// top level of the long-period precession and obliquity unit
//
//  channel  ports                                     moves
//  s_       s_valid s_ready s_time_centuries          time in centuries, q11.20
//  m_       m_valid m_ready m_precession_longitude    longitude and obliquity,
//           m_obliquity                               arcsec q16
//
// one transaction per clock sustained while m_ready holds; items pass the front
// pipeline, queue and back pipeline (the 28-step cordic sets most of the latency)
// reset clears only valid bits, queue pointers and count; payloads are not reset
// a stalled m_ channel freezes the back pipeline; the queue keeps the front running
// until it fills, then s_ready drops
module general_precession_obliquity_unit #(
    parameter int NUM_TERMS       = 10,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_time_centuries,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [47:0]                m_precession_longitude,
    output logic signed [47:0]                m_obliquity
);

    localparam int OW = gpo_pkg::OUT_W;
    localparam int PW = gpo_pkg::PHASE_W;
    localparam int QW = NUM_TERMS * PW + 2 * OW;

    // front end outputs
    logic                         f_valid;
    logic [NUM_TERMS-1:0][PW-1:0] f_phase;
    logic [OW-1:0]                f_pa, f_ea;

    // queue
    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_din, q_dout;

    // back end inputs unpacked from the queue head
    logic [NUM_TERMS-1:0][PW-1:0] b_phase;
    logic [OW-1:0]                b_pa, b_ea, o_pa, o_ea;

    gpo_front #(
        .NUM_TERMS(NUM_TERMS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_time   (s_time_centuries),
        .out_valid (f_valid),
        .out_full  (q_full),
        .out_phase (f_phase),
        .out_pa    (f_pa),
        .out_ea    (f_ea)
    );

    // a finished front item moves into the queue whenever there is room
    assign q_push = f_valid && !q_full;
    assign q_din  = {f_phase, f_pa, f_ea};

    gpo_queue #(
        .WIDTH(QW),
        .DEPTH(gpo_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {b_phase, b_pa, b_ea} = q_dout;

    gpo_back #(
        .NUM_TERMS       (NUM_TERMS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_avail  (!q_empty),
        .in_pop    (q_pop),
        .in_phase  (b_phase),
        .in_pa     (b_pa),
        .in_ea     (b_ea),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pa    (o_pa),
        .out_ea    (o_ea)
    );

    // results wrap to 48 bits
    assign m_precession_longitude = $signed(o_pa);
    assign m_obliquity            = $signed(o_ea);

endmodule

### dv/testbench.sv
// testbench for the long-period precession and obliquity unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS  = 16;
    localparam int NUM_RANDOM  = 1400;
    localparam int DRAIN_WAIT  = 60;      // comfortably above the pipeline latency
    localparam int STALL_HOLD  = 300;     // long output stall to back the pipeline up
    localparam int STALL_AFTER = 500;     // result count at which the long stall starts

    typedef struct {
        logic [gpo_pkg::OUT_W-1:0] longitude;
        logic [gpo_pkg::OUT_W-1:0] obliquity;
    } angle_pair_t;

    // predicts both angles for each accepted time and checks results in order
    class obliquity_scoreboard;
        angle_pair_t pending_angles[$];
        int mismatches;
        int checked;

        // add half, then floor shift, so ties round up
        static function longint round_shift(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        static function void sincos_of_phase(logic [31:0] phase, output longint sn,
                                             output longint cs);
            logic [31:0] folded;
            logic [1:0]  quarter;
            longint x, y, z, nx, rs, rc;
            folded  = phase + 32'h2000_0000;
            quarter = folded[31:30];
            z = longint'({34'd0, folded[29:0]}) - 64'sh2000_0000;
            x = longint'(gpo_pkg::CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < gpo_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(gpo_pkg::ATAN_TURNS[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(gpo_pkg::ATAN_TURNS[i]);
                end
                x = nx;
            end
            rs = round_shift(y, 30 - ANGLE_BITS);
            rc = round_shift(x, 30 - ANGLE_BITS);
            case (quarter)
                2'd0: begin sn = rs;  cs = rc;  end
                2'd1: begin sn = rc;  cs = -rs; end
                2'd2: begin sn = -rs; cs = -rc; end
                default: begin sn = -rc; cs = rs; end
            endcase
        endfunction

        static function angle_pair_t predict_angles(logic signed [31:0] time_q20);
            angle_pair_t res;
            longint t, t2q20, t2q8, t3q8, pa, ea, sn, cs;
            logic [63:0] sq, prod;
            t     = longint'(time_q20);
            sq    = 64'(t * t);
            t2q20 = longint'(sq >> 20);
            t2q8  = longint'(sq >> 32);
            t3q8  = (t2q8 * t) >>> 20;
            pa = longint'(gpo_pkg::P0_Q16) + round_shift(longint'(gpo_pkg::P1_Q19) * t, 23)
                 - round_shift(longint'(gpo_pkg::P2_Q28) * t2q20, 32)
                 + round_shift(longint'(gpo_pkg::P3_Q49) * t3q8, 41);
            ea = longint'(gpo_pkg::E0_Q16) - round_shift(longint'(gpo_pkg::E1_Q36) * t, 40)
                 - round_shift(longint'(gpo_pkg::E2_Q40) * t2q20, 44);
            for (int i = 0; i < gpo_pkg::TERM_SLOTS; i++) begin
                prod = 64'(t) * 64'(gpo_pkg::TERM_RECIP[i]);
                sincos_of_phase(prod[63:32], sn, cs);
                pa += round_shift(longint'(gpo_pkg::TERM_PC[i]) * cs
                                  + longint'(gpo_pkg::TERM_PS[i]) * sn, ANGLE_BITS);
                ea += round_shift(longint'(gpo_pkg::TERM_EC[i]) * cs
                                  + longint'(gpo_pkg::TERM_ES[i]) * sn, ANGLE_BITS);
            end
            res.longitude = pa[gpo_pkg::OUT_W-1:0];
            res.obliquity = ea[gpo_pkg::OUT_W-1:0];
            return res;
        endfunction

        function void note_time(logic signed [31:0] time_q20);
            pending_angles.push_back(predict_angles(time_q20));
        endfunction

        function void check_angles(logic [gpo_pkg::OUT_W-1:0] longitude,
                                   logic [gpo_pkg::OUT_W-1:0] obliquity);
            angle_pair_t exp_pair;
            checked++;
            if (pending_angles.size() == 0) begin
                $error("result with no expectation pending: longitude %h obliquity %h",
                       longitude, obliquity);
                mismatches++;
                return;
            end
            exp_pair = pending_angles.pop_front();
            if (longitude !== exp_pair.longitude) begin
                $error("precession_longitude: expected %h, actual %h",
                       exp_pair.longitude, longitude);
                mismatches++;
            end
            if (obliquity !== exp_pair.obliquity) begin
                $error("obliquity: expected %h, actual %h", exp_pair.obliquity, obliquity);
                mismatches++;
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [31:0]               s_time_centuries = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [gpo_pkg::OUT_W-1:0] m_precession_longitude;
    logic signed [gpo_pkg::OUT_W-1:0] m_obliquity;

    obliquity_scoreboard angle_board = new();
    int  times_sent;
    bit  stall_seen;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;

    always #1 aclk = ~aclk;

    general_precession_obliquity_unit i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_time_centuries       (s_time_centuries),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_precession_longitude (m_precession_longitude),
        .m_obliquity            (m_obliquity)
    );

    // both monitors sample the values that were stable before the edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            angle_board.note_time(s_time_centuries);
        end
        if (aresetn && m_valid && m_ready) begin
            angle_board.check_angles(m_precession_longitude, m_obliquity);
        end
    end

    // offer one time value; valid stays high across back-to-back transactions
    task automatic send_time(logic signed [31:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_time_centuries <= value;
        do @(posedge aclk); while (!s_ready);
        times_sent++;
    endtask

    // draws a mix: mostly realistic epochs, some full-range noise
    function automatic logic signed [31:0] random_time();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            2:       return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
        endcase
    endfunction

    // result side: random back-pressure plus one long hold-off
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (!stall_seen && angle_board.checked >= STALL_AFTER) begin
                stall_seen = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_HOLD) @(posedge aclk);
            end else begin
                gap = receiver_idles ? $urandom_range(0, 13) : 0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // idling on or off per stretch of clocks so some phases run at full rate
    initial begin
        forever begin
            repeat (100) @(posedge aclk);
            sender_idles   = $urandom_range(0, 2) != 0;
            receiver_idles = $urandom_range(0, 2) != 0;
        end
    end

    initial begin
        logic signed [31:0] directed_times[$];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // range extremes, unit epochs, alternating bit patterns, tiny steps
        directed_times = '{32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001,
                           32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0010_0000,
                           -32'sh0010_0000, 32'shAAAA_AAAA, 32'sh5555_5555,
                           32'sh0100_0000, -32'sh0100_0000, 32'sh4000_0000,
                           32'shC000_0000, 32'sh0000_8000, 32'shFFF0_0001,
                           32'sh0640_0000, -32'sh0640_0000, 32'sh3FFF_FFFF};
        foreach (directed_times[i]) send_time(directed_times[i]);

        for (int n = 0; n < NUM_RANDOM; n++) send_time(random_time());
        s_valid <= 1'b0;

        wait (angle_board.pending_angles.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d time values sent, %0d results checked", times_sent, angle_board.checked);
        $display("full-range and realistic epochs covered, long output stall applied: %0d",
                 stall_seen);
        if (angle_board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
